// ===== hdl/vcs_pkg.sv =====
`default_nettype none

package vcs_pkg;

  localparam int unsigned DataW = 24;
  localparam int unsigned FracB = 12;
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned ThrW  = DataW - 1;

  // one in the fixed point format
  localparam logic signed [DataW-1:0] QOne =
    {{(DataW-FracB-1){1'b0}}, 1'b1, {FracB{1'b0}}};
  localparam logic signed [DataW-1:0] QMinusOne = -QOne;

  localparam logic [ThrW-1:0] ThrReset =
    {{(ThrW-FracB-2){1'b0}}, 2'b10, {FracB{1'b0}}};
  localparam logic [DataW-1:0] MinFwdReset =
    {{(DataW-FracB-1){1'b0}}, 1'b1, {FracB{1'b0}}};

  localparam logic signed [ProdW-1:0] SMaxW =
    {{(ProdW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
  localparam logic signed [ProdW-1:0] SMinW =
    {{(ProdW-DataW+1){1'b1}}, {(DataW-1){1'b0}}};

  typedef enum logic [0:0] {
    CfgThreshold = 1'b0,
    CfgMinFwd    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] raw_x;
    logic signed [DataW-1:0] raw_y;
    logic signed [DataW-1:0] raw_z;
    logic signed [DataW-1:0] desired_speed;
    logic signed [DataW-1:0] fwd_pos;
  } vcs_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] vel_x;
    logic signed [DataW-1:0] vel_y;
    logic signed [DataW-1:0] vel_z;
  } vcs_out_t;

  // vector plus the speed it is scaled by
  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
    logic signed [DataW-1:0] speed;
  } vcs_vec_t;

  function automatic logic signed [DataW-1:0] sat_word(input logic signed [ProdW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > SMaxW) begin
      r = SMaxW[DataW-1:0];
    end else if (v < SMinW) begin
      r = SMinW[DataW-1:0];
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/velocity_command_shaper.sv =====
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+--------------------------------
// input    | start_i, busy_o, in_i                   | beat when start_i && !busy_o
// result   | res_valid_o, res_o                      | beat on each res_valid_o cycle
// config   | cfg_we_i, cfg_idx_i, cfg_wdata_i        | write when cfg_we_i is high
//
// one beat in per cycle, busy_o is never raised; each beat gives one result
// latency is set by the slower of the bit-per-stage ramp divider and the
// square root + normalize chain; the faster branch is delayed to match
// reset clears all valid bits and loads the default threshold and floor
// the receiver cannot stall, so results leave on the strobe and are gone
`default_nettype none

module velocity_command_shaper import vcs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire vcs_in_t          in_i,
  input  wire logic             cfg_we_i,
  input  wire cfg_idx_e         cfg_idx_i,
  input  wire logic [DataW-1:0] cfg_wdata_i,
  output logic                  res_valid_o,
  output vcs_out_t              res_o
);

  // pipeline depths of the two branches
  localparam int unsigned LatVec  = DataW + FracB + 6;
  localparam int unsigned LatRamp = 2 * DataW + 1;
  localparam int unsigned LatMax  = (LatVec > LatRamp) ? LatVec : LatRamp;

  // fully pipelined, so every start is taken
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [ThrW-1:0]  thr_q, thr_d;
  logic [DataW-1:0] minf_q, minf_d;
  logic [ThrW-1:0]  dvs;

  always_comb begin
    thr_d  = thr_q;
    minf_d = minf_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgThreshold: thr_d  = cfg_wdata_i[ThrW-1:0];
        CfgMinFwd:    minf_d = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThrReset;
      minf_q <= MinFwdReset;
    end else begin
      thr_q  <= thr_d;
      minf_q <= minf_d;
    end
  end

  // a zero threshold divides by one, but still compares against zero
  assign dvs = (thr_q == '0) ? {{(ThrW-1){1'b0}}, 1'b1} : thr_q;

  // ---------------------------------------------------------------
  // stage 1: clip x, square the components, form the ramp product
  // ---------------------------------------------------------------
  logic                    in_vld;
  logic signed [DataW-1:0] cx;
  logic                    s1_vld_q;
  vcs_vec_t                s1_vec_q, s1_vec_d;
  logic        [ProdW-1:0] sqx_q, sqy_q, sqz_q;
  logic signed [ProdW-1:0] sqx_d, sqy_d, sqz_d;
  logic signed [ProdW-1:0] rp_q, rp_d;
  logic                    ren_q, ren_d;

  assign in_vld = start_i && !busy_o;

  always_comb begin
    if (in_i.raw_x > QOne) begin
      cx = QOne;
    end else if (in_i.raw_x < QMinusOne) begin
      cx = QMinusOne;
    end else begin
      cx = in_i.raw_x;
    end
    s1_vec_d.x     = cx;
    s1_vec_d.y     = in_i.raw_y;
    s1_vec_d.z     = in_i.raw_z;
    s1_vec_d.speed = in_i.desired_speed;
    sqx_d = $signed(cx) * $signed(cx);
    sqy_d = $signed(in_i.raw_y) * $signed(in_i.raw_y);
    sqz_d = $signed(in_i.raw_z) * $signed(in_i.raw_z);
    rp_d  = $signed(in_i.fwd_pos) * $signed(in_i.desired_speed);
    ren_d = $signed(in_i.fwd_pos) < $signed({1'b0, thr_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_vec_q <= s1_vec_d;
    sqx_q    <= ProdW'(sqx_d);
    sqy_q    <= ProdW'(sqy_d);
    sqz_q    <= ProdW'(sqz_d);
    rp_q     <= rp_d;
    ren_q    <= ren_d;
  end

  // ---------------------------------------------------------------
  // stage 2: sum of squares, always below 2^ProdW
  // ---------------------------------------------------------------
  logic             s2_vld_q;
  vcs_vec_t         s2_vec_q;
  logic [ProdW-1:0] sum_q, sum_d;

  assign sum_d = sqx_q + sqy_q + sqz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_vec_q <= s1_vec_q;
    sum_q    <= sum_d;
  end

  // ---------------------------------------------------------------
  // length, then component / length
  // ---------------------------------------------------------------
  logic             sq_vld;
  logic [DataW-1:0] sq_len;
  vcs_vec_t         sq_vec;
  logic             nd_vld;
  vcs_vec_t         nd_vec;

  vcs_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s2_vld_q),
    .sum_i  (sum_q),
    .vec_i  (s2_vec_q),
    .vld_o  (sq_vld),
    .root_o (sq_len),
    .vec_o  (sq_vec)
  );

  vcs_norm_div u_norm_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sq_vld),
    .len_i  (sq_len),
    .vec_i  (sq_vec),
    .vld_o  (nd_vld),
    .vec_o  (nd_vec)
  );

  // ---------------------------------------------------------------
  // speed scaling: register, multiply, floor shift and saturate
  // ---------------------------------------------------------------
  logic                    sc1_vld_q;
  vcs_vec_t                sc1_vec_q;
  logic                    sc2_vld_q;
  logic signed [ProdW-1:0] px_q, py_q, pz_q;
  logic signed [ProdW-1:0] px_d, py_d, pz_d;
  logic                    sc3_vld_q;
  vcs_out_t                sc3_q, sc3_d;

  assign px_d = $signed(sc1_vec_q.x) * $signed(sc1_vec_q.speed);
  assign py_d = $signed(sc1_vec_q.y) * $signed(sc1_vec_q.speed);
  assign pz_d = $signed(sc1_vec_q.z) * $signed(sc1_vec_q.speed);

  always_comb begin
    sc3_d.vel_x = sat_word(px_q >>> FracB);
    sc3_d.vel_y = sat_word(py_q >>> FracB);
    sc3_d.vel_z = sat_word(pz_q >>> FracB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc1_vld_q <= 1'b0;
      sc2_vld_q <= 1'b0;
      sc3_vld_q <= 1'b0;
    end else begin
      sc1_vld_q <= nd_vld;
      sc2_vld_q <= sc1_vld_q;
      sc3_vld_q <= sc2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sc1_vec_q <= nd_vec;
    px_q      <= px_d;
    py_q      <= py_d;
    pz_q      <= pz_d;
    sc3_q     <= sc3_d;
  end

  // ---------------------------------------------------------------
  // ramp branch: floor(position * speed / threshold)
  // ---------------------------------------------------------------
  logic                    rd_vld;
  logic                    rd_en;
  logic signed [ProdW-1:0] rd_ramp;

  vcs_ramp_div u_ramp_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s1_vld_q),
    .en_i   (ren_q),
    .prod_i (rp_q),
    .dvs_i  (dvs),
    .vld_o  (rd_vld),
    .en_o   (rd_en),
    .ramp_o (rd_ramp)
  );

  // ---------------------------------------------------------------
  // line the two branches up
  // ---------------------------------------------------------------
  logic                 al_vec_vld;
  logic [3*DataW-1:0]   al_vec_dat;
  logic                 al_rmp_vld;
  logic [ProdW:0]       al_rmp_dat;
  vcs_out_t             al_vec;
  logic                 al_en;
  logic signed [ProdW-1:0] al_ramp;

  vcs_delay #(
    .Width (3 * DataW),
    .Depth (LatMax - LatVec)
  ) u_vec_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sc3_vld_q),
    .dat_i  (sc3_q),
    .vld_o  (al_vec_vld),
    .dat_o  (al_vec_dat)
  );

  vcs_delay #(
    .Width (ProdW + 1),
    .Depth (LatMax - LatRamp)
  ) u_rmp_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld),
    .dat_i  ({rd_en, rd_ramp}),
    .vld_o  (al_rmp_vld),
    .dat_o  (al_rmp_dat)
  );

  assign al_vec  = al_vec_dat;
  assign al_en   = al_rmp_dat[ProdW];
  assign al_ramp = $signed(al_rmp_dat[ProdW-1:0]);

  // ---------------------------------------------------------------
  // merge: below threshold the forward command is max(ramp, floor)
  // ---------------------------------------------------------------
  logic                    out_vld_q;
  vcs_out_t                out_q, out_d;
  logic signed [ProdW-1:0] lo;
  logic signed [ProdW-1:0] mx;

  always_comb begin
    lo    = $signed({{(ProdW-DataW){minf_q[DataW-1]}}, minf_q});
    mx    = (al_ramp > lo) ? al_ramp : lo;
    out_d = al_vec;
    if (al_en) begin
      out_d.vel_x = sat_word(mx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= al_vec_vld && al_rmp_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

// ===== hdl/vcs_delay.sv =====
`default_nettype none

module vcs_delay #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             vld_i,
  input  wire logic [Width-1:0] dat_i,
  output logic                  vld_o,
  output logic      [Width-1:0] dat_o
);

  if (Depth == 0) begin : g_none
    assign vld_o = vld_i;
    assign dat_o = dat_i;
  end else begin : g_line
    logic             vld_q [Depth];
    logic [Width-1:0] dat_q [Depth];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < Depth; i++) vld_q[i] <= 1'b0;
      end else begin
        vld_q[0] <= vld_i;
        for (int i = 1; i < Depth; i++) vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      dat_q[0] <= dat_i;
      for (int i = 1; i < Depth; i++) dat_q[i] <= dat_q[i-1];
    end

    assign vld_o = vld_q[Depth-1];
    assign dat_o = dat_q[Depth-1];
  end

endmodule

`default_nettype wire

// ===== hdl/vcs_sqrt.sv =====
`default_nettype none

module vcs_sqrt import vcs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             vld_i,
  input  wire logic [ProdW-1:0] sum_i,
  input  wire vcs_vec_t         vec_i,
  output logic                  vld_o,
  output logic      [DataW-1:0] root_o,
  output vcs_vec_t              vec_o
);

  localparam int unsigned NStg = DataW;
  localparam int unsigned RemW = DataW + 2;

  logic             vld_q  [NStg];
  logic [RemW-1:0]  rem_q  [NStg];
  logic [RemW-1:0]  rem_d  [NStg];
  logic [DataW-1:0] root_q [NStg];
  logic [DataW-1:0] root_d [NStg];
  logic [ProdW-1:0] sum_q  [NStg];
  logic [ProdW-1:0] sum_d  [NStg];
  vcs_vec_t         vec_q  [NStg];

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < NStg; k++) begin : g_stg
    logic             vld_in;
    logic [RemW-1:0]  rem_in;
    logic [DataW-1:0] root_in;
    logic [ProdW-1:0] sum_in;
    vcs_vec_t         vec_in;
    logic [RemW-1:0]  trial;
    logic [RemW-1:0]  tst;

    if (k == 0) begin : g_src
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sum_in  = sum_i;
      assign vec_in  = vec_i;
    end else begin : g_src
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sum_in  = sum_q[k-1];
      assign vec_in  = vec_q[k-1];
    end

    always_comb begin
      trial = {rem_in[RemW-3:0], sum_in[ProdW-1 -: 2]};
      tst   = {root_in, 2'b01};
      if (trial >= tst) begin
        rem_d[k]  = trial - tst;
        root_d[k] = {root_in[DataW-2:0], 1'b1};
      end else begin
        rem_d[k]  = trial;
        root_d[k] = {root_in[DataW-2:0], 1'b0};
      end
      sum_d[k] = {sum_in[ProdW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      sum_q[k]  <= sum_d[k];
      vec_q[k]  <= vec_in;
    end
  end

  assign vld_o  = vld_q[NStg-1];
  assign root_o = root_q[NStg-1];
  assign vec_o  = vec_q[NStg-1];

endmodule

`default_nettype wire

// ===== hdl/vcs_norm_div.sv =====
`default_nettype none

module vcs_norm_div import vcs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             vld_i,
  input  wire logic [DataW-1:0] len_i,
  input  wire vcs_vec_t         vec_i,
  output logic                  vld_o,
  output vcs_vec_t              vec_o
);

  // quotient of a component by the length never exceeds one
  localparam int unsigned NStg = FracB + 1;
  localparam int unsigned QW   = FracB + 1;

  logic             vld_q [NStg];
  logic [DataW-1:0] len_q [NStg];
  vcs_vec_t         vec_q [NStg];
  logic [2:0]       neg_q [NStg];
  logic [DataW-1:0] rem_q [NStg][3];
  logic [DataW-1:0] rem_d [NStg][3];
  logic [QW-1:0]    quo_q [NStg][3];
  logic [QW-1:0]    quo_d [NStg][3];

  logic signed [DataW-1:0] comp [3];
  logic [2:0]              neg_in0;
  logic [DataW-1:0]        mag  [3];

  always_comb begin
    comp[0] = vec_i.x;
    comp[1] = vec_i.y;
    comp[2] = vec_i.z;
    for (int l = 0; l < 3; l++) begin
      neg_in0[l] = comp[l][DataW-1];
      mag[l]     = comp[l][DataW-1] ? DataW'(-comp[l]) : DataW'(comp[l]);
    end
  end

  for (genvar k = 0; k < NStg; k++) begin : g_stg
    logic             vld_in;
    logic [DataW-1:0] len_in;
    vcs_vec_t         vec_in;
    logic [2:0]       neg_in;
    logic [DataW:0]   trial [3];
    logic             ge    [3];

    if (k == 0) begin : g_src
      assign vld_in = vld_i;
      assign len_in = len_i;
      assign vec_in = vec_i;
      assign neg_in = neg_in0;
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          trial[l] = {1'b0, mag[l]};
        end
      end
    end else begin : g_src
      assign vld_in = vld_q[k-1];
      assign len_in = len_q[k-1];
      assign vec_in = vec_q[k-1];
      assign neg_in = neg_q[k-1];
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          trial[l] = {rem_q[k-1][l], 1'b0};
        end
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        ge[l] = trial[l] >= {1'b0, len_in};
        if (ge[l]) begin
          rem_d[k][l] = DataW'(trial[l] - {1'b0, len_in});
        end else begin
          rem_d[k][l] = trial[l][DataW-1:0];
        end
        if (k == 0) begin
          quo_d[k][l] = {{(QW-1){1'b0}}, ge[l]};
        end else begin
          quo_d[k][l] = {quo_q[(k == 0) ? 0 : k-1][l][QW-2:0], ge[l]};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      len_q[k] <= len_in;
      vec_q[k] <= vec_in;
      neg_q[k] <= neg_in;
      for (int l = 0; l < 3; l++) begin
        rem_q[k][l] <= rem_d[k][l];
        quo_q[k][l] <= quo_d[k][l];
      end
    end
  end

  // sign back on, truncation toward zero; zero length keeps the vector
  logic signed [DataW-1:0] nrm [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (neg_q[NStg-1][l]) begin
        nrm[l] = -$signed({{(DataW-QW){1'b0}}, quo_q[NStg-1][l]});
      end else begin
        nrm[l] = $signed({{(DataW-QW){1'b0}}, quo_q[NStg-1][l]});
      end
    end
    vec_o.speed = vec_q[NStg-1].speed;
    if (len_q[NStg-1] == '0) begin
      vec_o.x = vec_q[NStg-1].x;
      vec_o.y = vec_q[NStg-1].y;
      vec_o.z = vec_q[NStg-1].z;
    end else begin
      vec_o.x = nrm[0];
      vec_o.y = nrm[1];
      vec_o.z = nrm[2];
    end
  end

  assign vld_o = vld_q[NStg-1];

endmodule

`default_nettype wire

// ===== hdl/vcs_ramp_div.sv =====
`default_nettype none

module vcs_ramp_div import vcs_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    vld_i,
  input  wire logic                    en_i,
  input  wire logic signed [ProdW-1:0] prod_i,
  input  wire logic        [ThrW-1:0]  dvs_i,
  output logic                         vld_o,
  output logic                         en_o,
  output logic signed      [ProdW-1:0] ramp_o
);

  // magnitude of a product of two words fits one bit less than the product
  localparam int unsigned MagW = ProdW - 1;
  localparam int unsigned NStg = MagW;

  logic            vld_q [NStg];
  logic            en_q  [NStg];
  logic            neg_q [NStg];
  logic [ThrW-1:0] rem_q [NStg];
  logic [ThrW-1:0] rem_d [NStg];
  logic [MagW-1:0] dvd_q [NStg];
  logic [MagW-1:0] dvd_d [NStg];
  logic [MagW-1:0] quo_q [NStg];
  logic [MagW-1:0] quo_d [NStg];

  logic [ProdW-1:0] mag0;

  assign mag0 = prod_i[ProdW-1] ? ProdW'(-prod_i) : ProdW'(prod_i);

  for (genvar k = 0; k < NStg; k++) begin : g_stg
    logic            vld_in;
    logic            en_in;
    logic            neg_in;
    logic [ThrW-1:0] rem_in;
    logic [MagW-1:0] dvd_in;
    logic [MagW-1:0] quo_in;
    logic [ThrW:0]   trial;

    if (k == 0) begin : g_src
      assign vld_in = vld_i;
      assign en_in  = en_i;
      assign neg_in = prod_i[ProdW-1];
      assign rem_in = '0;
      assign dvd_in = mag0[MagW-1:0];
      assign quo_in = '0;
    end else begin : g_src
      assign vld_in = vld_q[k-1];
      assign en_in  = en_q[k-1];
      assign neg_in = neg_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      trial = {rem_in, dvd_in[MagW-1]};
      if (trial >= {1'b0, dvs_i}) begin
        rem_d[k] = ThrW'(trial - {1'b0, dvs_i});
        quo_d[k] = {quo_in[MagW-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[ThrW-1:0];
        quo_d[k] = {quo_in[MagW-2:0], 1'b0};
      end
      dvd_d[k] = {dvd_in[MagW-2:0], 1'b0};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      en_q[k]  <= en_in;
      neg_q[k] <= neg_in;
      rem_q[k] <= rem_d[k];
      dvd_q[k] <= dvd_d[k];
      quo_q[k] <= quo_d[k];
    end
  end

  // floor for negative products: round the magnitude up when inexact
  logic                    fvld_q;
  logic                    fen_q;
  logic signed [ProdW-1:0] res_q;
  logic signed [ProdW-1:0] res_d;
  logic        [ProdW-1:0] up;

  always_comb begin
    up = {1'b0, quo_q[NStg-1]} + {{(ProdW-1){1'b0}}, (rem_q[NStg-1] != '0)};
    if (neg_q[NStg-1]) begin
      res_d = -$signed(up);
    end else begin
      res_d = $signed({1'b0, quo_q[NStg-1]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvld_q <= 1'b0;
    end else begin
      fvld_q <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    fen_q <= en_q[NStg-1];
    res_q <= res_d;
  end

  assign vld_o  = fvld_q;
  assign en_o   = fen_q;
  assign ramp_o = res_q;

endmodule

`default_nettype wire

// ===== test/velocity_command_shaper_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none

module velocity_command_shaper_tb;
  import vcs_pkg::*;

  localparam int unsigned LatCycles = 50;
  localparam longint CycleLimit = 400000;
  localparam int unsigned RandBeats = 1550;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  vcs_in_t          in_i;
  logic             cfg_we_i;
  cfg_idx_e         cfg_idx_i;
  logic [DataW-1:0] cfg_wdata_i;
  logic             res_valid_o;
  vcs_out_t         res_o;

  velocity_command_shaper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // shadow copy of the two registers
  logic [ThrW-1:0]  thr_shadow;
  logic [DataW-1:0] min_fwd_shadow;

  vcs_in_t  cmd_queue[$];       // beats waiting for the driver
  vcs_out_t vel_expected[$];    // predicted velocity commands, oldest first
  int       err_count;
  int       beats_sent;
  int       beats_checked;
  bit       quiet_mode;         // long stretch with no idle cycles
  longint   cycle_count;

  localparam longint SMax = (longint'(1) <<< (DataW - 1)) - 1;
  localparam longint SMin = -SMax - 1;
  localparam longint OneQ = longint'(1) <<< FracB;

  function automatic longint clamp_word(longint v);
    if (v > SMax) return SMax;
    if (v < SMin) return SMin;
    return v;
  endfunction

  function automatic longint div_floor(longint p, longint d);
    longint q;
    q = p / d;
    if ((p % d != 0) && p < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint root;
    longint rem_v;
    longint bitv;
    root = 0;
    rem_v = v;
    bitv = longint'(1) <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (rem_v >= root + bitv) begin
        rem_v = rem_v - (root + bitv);
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return root;
  endfunction

  // clip, normalize, scale, then forward ramp
  function automatic vcs_out_t shape_velocity(vcs_in_t c);
    longint comp[3];
    longint spd;
    longint pos;
    longint thr;
    longint len;
    longint ramp;
    longint lo;
    vcs_out_t r;
    comp[0] = longint'(c.raw_x);
    comp[1] = longint'(c.raw_y);
    comp[2] = longint'(c.raw_z);
    spd = longint'(c.desired_speed);
    pos = longint'(c.fwd_pos);
    thr = longint'(thr_shadow);
    if (comp[0] > OneQ) comp[0] = OneQ;
    if (comp[0] < -OneQ) comp[0] = -OneQ;
    len = int_sqrt(comp[0] * comp[0] + comp[1] * comp[1] + comp[2] * comp[2]);
    for (int i = 0; i < 3; i++) begin
      if (len != 0) comp[i] = (comp[i] * OneQ) / len;
      comp[i] = clamp_word(div_floor(comp[i] * spd, OneQ));
    end
    if (pos < thr) begin
      // zero threshold divides by one
      ramp = div_floor(pos * spd, (thr > 0) ? thr : 1);
      lo = longint'($signed(min_fwd_shadow));
      comp[0] = clamp_word((ramp > lo) ? ramp : lo);
    end
    r.vel_x = comp[0][DataW-1:0];
    r.vel_y = comp[1][DataW-1:0];
    r.vel_z = comp[2][DataW-1:0];
    return r;
  endfunction

  // driver: pops a pending beat, but idles at random 38 times in 100 outside quiet mode
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        vel_expected.insert(vel_expected.size(), shape_velocity(in_i));
        beats_sent <= beats_sent + 1;
      end
      if ((!start_i || !busy_o) && cmd_queue.size() > 0 &&
          (quiet_mode || $urandom_range(99) >= 38)) begin
        in_i    <= cmd_queue.pop_front();
        start_i <= 1'b1;
      end else if (!start_i || !busy_o) begin
        start_i <= 1'b0;
        in_i    <= vcs_in_t'($bits(vcs_in_t)'({$urandom, $urandom, $urandom, $urandom}));
      end
    end
  end

  // monitor: every strobe is a result beat
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && res_valid_o) begin
      if (vel_expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_o);
        err_count <= err_count + 1;
      end else begin
        vcs_out_t e;
        e = vel_expected.pop_front();
        if (res_o.vel_x !== e.vel_x || res_o.vel_y !== e.vel_y ||
            res_o.vel_z !== e.vel_z) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h actual x=%h y=%h z=%h",
                   $time, e.vel_x, e.vel_y, e.vel_z,
                   res_o.vel_x, res_o.vel_y, res_o.vel_z);
          err_count <= err_count + 1;
        end
        beats_checked <= beats_checked + 1;
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [DataW-1:0] rand_word();
    case ($urandom_range(5))
      0: return {1'b0, {(DataW-1){1'b1}}};
      1: return {1'b1, {(DataW-1){1'b0}}};
      2: return DataW'($signed($urandom_range(2 * OneQ) - OneQ));
      3: return DataW'($signed($urandom_range(16 * OneQ) - 8 * OneQ));
      default: return DataW'($urandom);
    endcase
  endfunction

  function automatic vcs_in_t rand_cmd();
    vcs_in_t c;
    c.raw_x = rand_word();
    c.raw_y = rand_word();
    c.raw_z = rand_word();
    c.desired_speed = rand_word();
    c.fwd_pos = rand_word();
    return c;
  endfunction

  function automatic vcs_in_t mk_cmd(longint x, longint y, longint z, longint s, longint p);
    vcs_in_t c;
    c.raw_x = x[DataW-1:0];
    c.raw_y = y[DataW-1:0];
    c.raw_z = z[DataW-1:0];
    c.desired_speed = s[DataW-1:0];
    c.fwd_pos = p[DataW-1:0];
    return c;
  endfunction

  // append a beat to the pending queue
  function automatic void queue_cmd(vcs_in_t c);
    cmd_queue.insert(cmd_queue.size(), c);
  endfunction

  // register write while idle, shadow follows
  task automatic write_reg(cfg_idx_e idx, logic [DataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgThreshold) thr_shadow = val[ThrW-1:0];
    else min_fwd_shadow = val;
  endtask

  task automatic drain();
    while (cmd_queue.size() > 0 || start_i || vel_expected.size() > 0)
      @(posedge clk_i);
    repeat (LatCycles + 5) @(posedge clk_i);
  endtask

  initial begin
    logic [DataW-1:0] thr_set[6];
    logic [DataW-1:0] min_set[6];
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgThreshold;
    cfg_wdata_i = '0;
    err_count = 0;
    beats_sent = 0;
    beats_checked = 0;
    cycle_count = 0;
    quiet_mode = 1'b0;
    thr_shadow = ThrReset;
    min_fwd_shadow = MinFwdReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed beats at reset register values
    queue_cmd(mk_cmd(0, 0, 0, OneQ, 0));               // zero length, ramp
    queue_cmd(mk_cmd(0, 0, 0, OneQ, 4 * OneQ));        // zero length, no ramp
    queue_cmd(mk_cmd(SMax, 0, 0, 2 * OneQ, 8 * OneQ)); // x clipped high
    queue_cmd(mk_cmd(SMin, 0, 0, 2 * OneQ, 8 * OneQ)); // x clipped low
    queue_cmd(mk_cmd(OneQ, OneQ, OneQ, 3 * OneQ, 8 * OneQ));
    queue_cmd(mk_cmd(0, SMax, SMin, SMax, SMax));      // saturating speed
    queue_cmd(mk_cmd(SMin, SMin, SMin, SMin, SMin));   // ramp overflow
    queue_cmd(mk_cmd(SMax, SMax, SMax, SMax, SMin));
    queue_cmd(mk_cmd(-OneQ, 3, -7, -OneQ, OneQ));      // tiny y and z components
    queue_cmd(mk_cmd(1, 0, 0, SMax, OneQ));
    queue_cmd(mk_cmd(-1, -1, -1, -1, -1));
    queue_cmd(mk_cmd(OneQ / 2, -OneQ, 2 * OneQ, OneQ, 2 * OneQ - 1));
    drain();

    // zero threshold: only negative positions ramp
    write_reg(CfgThreshold, '0);
    write_reg(CfgMinFwd, {1'b1, {(DataW-1){1'b0}}});
    queue_cmd(mk_cmd(OneQ, 0, OneQ, 5 * OneQ, -3 * OneQ));
    queue_cmd(mk_cmd(OneQ, 0, OneQ, 5 * OneQ, 0));
    queue_cmd(mk_cmd(OneQ, OneQ, 0, SMax, SMin));
    queue_cmd(mk_cmd(OneQ, 0, 0, -OneQ, -1));
    drain();

    thr_set = '{{1'b0, {(DataW-1){1'b1}}}, 24'd1, 24'd8192, 24'd40960,
                24'h2aaaaa, 24'h555555};
    min_set = '{{1'b1, {(DataW-1){1'b0}}}, {1'b0, {(DataW-1){1'b1}}}, 24'd0,
                24'hfff000, 24'h2aaaaa, 24'h555555};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CfgThreshold, thr_set[ph]);
      write_reg(CfgMinFwd, min_set[ph]);
      quiet_mode = (ph == 2);
      for (int k = 0; k < RandBeats / 6 + 1; k++) queue_cmd(rand_cmd());
      drain();
    end
    quiet_mode = 1'b0;

    $display("covered %0d command beats, %0d results checked", beats_sent, beats_checked);
    $display("register sweep included zero, one and full-scale threshold and floor");
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/vcs_pkg.sv
hdl/vcs_delay.sv
hdl/vcs_sqrt.sv
hdl/vcs_norm_div.sv
hdl/vcs_ramp_div.sv
hdl/velocity_command_shaper.sv
test/velocity_command_shaper_tb.sv
